// ----- design/cdfs_pkg.sv -----
// Package for the clock display frame serializer.
// Holds the request and response payload types, frame constants and segment tables.
// No dependencies.
package cdfs_pkg;

   localparam int FRAME_DATA_BITS = 34;
   localparam int POS_W           = 8;

   // A frame's header and data part runs pulse positions 0 through 36.
   localparam logic [POS_W-1:0] HEAD_DATA_POS = 8'd3;
   localparam logic [POS_W-1:0] HEAD_ONE_POS  = 8'd1;
   localparam logic [POS_W-1:0] HEAD_LAST_POS = 8'd36;

   typedef logic [FRAME_DATA_BITS-1:0] frame_type;

   typedef struct packed {
      logic       start_req;
      logic [4:0] hour;
      logic [5:0] minute;
   } req_type;

   typedef struct packed {
      logic clock_pulse;
      logic data_level;
      logic busy_res;
      logic frame_done;
   } rsp_type;

   function automatic logic [7:0] hour_segs(input logic [3:0] digit);
      logic [7:0] segs;
      case (digit)
         4'd0:    segs = 8'h7E;
         4'd1:    segs = 8'h48;
         4'd2:    segs = 8'h3D;
         4'd3:    segs = 8'h6D;
         4'd4:    segs = 8'h4B;
         4'd5:    segs = 8'h67;
         4'd6:    segs = 8'h77;
         4'd7:    segs = 8'h4C;
         4'd8:    segs = 8'h7F;
         4'd9:    segs = 8'h6F;
         default: segs = 8'h00;
      endcase
      return segs;
   endfunction

   function automatic logic [7:0] minute_segs(input logic [3:0] digit);
      logic [7:0] segs;
      case (digit)
         4'd0:    segs = 8'hE7;
         4'd1:    segs = 8'h21;
         4'd2:    segs = 8'hCB;
         4'd3:    segs = 8'h6B;
         4'd4:    segs = 8'h2D;
         4'd5:    segs = 8'h6E;
         4'd6:    segs = 8'hEE;
         4'd7:    segs = 8'h23;
         4'd8:    segs = 8'hEF;
         4'd9:    segs = 8'h6F;
         default: segs = 8'h00;
      endcase
      return segs;
   endfunction

endpackage

// ----- design/cdfs_frame_pack.sv -----
// Splits hour and minute into decimal digits and packs the 34-bit display frame.
// Depends on cdfs_pkg for the frame type and the segment tables.
module cdfs_frame_pack (
   input  logic [4:0]         hour,
   input  logic [5:0]         minute,
   input  logic               colon,
   output cdfs_pkg::frame_type frame
);
   import cdfs_pkg::*;

   logic [3:0] hour_tens;
   logic [3:0] hour_units;
   logic [3:0] min_tens;
   logic [3:0] min_units;
   logic [6:0] hour_base;
   logic [6:0] min_base;

   // Tens digits come from a short compare chain; the ranges are small.
   always_comb begin
      if (hour >= 5'd30)      hour_tens = 4'd3;
      else if (hour >= 5'd20) hour_tens = 4'd2;
      else if (hour >= 5'd10) hour_tens = 4'd1;
      else                    hour_tens = 4'd0;

      if (minute >= 6'd60)      min_tens = 4'd6;
      else if (minute >= 6'd50) min_tens = 4'd5;
      else if (minute >= 6'd40) min_tens = 4'd4;
      else if (minute >= 6'd30) min_tens = 4'd3;
      else if (minute >= 6'd20) min_tens = 4'd2;
      else if (minute >= 6'd10) min_tens = 4'd1;
      else                      min_tens = 4'd0;

      hour_base  = 7'(hour_tens) * 7'd10;
      min_base   = 7'(min_tens) * 7'd10;
      hour_units = 4'(7'(hour) - hour_base);
      min_units  = 4'(7'(minute) - min_base);
   end

   assign frame = {hour_segs(hour_units), hour_segs(hour_tens), colon, colon,
                   minute_segs(min_tens), minute_segs(min_units)};

endmodule

// ----- design/cdfs_sequencer.sv -----
// Pulse sequencer: holds the frame state and produces one pulse result per step.
// Depends on cdfs_pkg and on cdfs_frame_pack for the latched frame contents.
module cdfs_sequencer #(
   parameter int TRAIL_PULSES = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  cdfs_pkg::req_type req,
   output cdfs_pkg::rsp_type rsp
);
   import cdfs_pkg::*;

   localparam logic [POS_W-1:0] TRAIL_LAST_POS = POS_W'(TRAIL_PULSES - 1);

   logic [POS_W-1:0] pulse_position_ff, pulse_position_in;
   frame_type        frame_bits_ff, frame_bits_in;
   logic             colon_flag_ff, colon_flag_in;
   logic             frame_active_ff, frame_active_in;
   logic             powerup_pending_ff, powerup_pending_in;
   logic             in_trail_ff, in_trail_in;

   frame_type        packed_frame;
   logic             take_start;
   logic             active;
   logic             trail;
   logic [POS_W-1:0] pos;
   frame_type        bits;

   cdfs_frame_pack u_pack (
      .hour   (req.hour),
      .minute (req.minute),
      .colon  (colon_flag_ff),
      .frame  (packed_frame)
   );

   always_comb begin
      take_start = !frame_active_ff && !powerup_pending_ff && req.start_req;
      active     = frame_active_ff || take_start;
      trail      = take_start ? 1'b0 : in_trail_ff;
      pos        = take_start ? '0 : pulse_position_ff;
      bits       = take_start ? packed_frame : frame_bits_ff;

      pulse_position_in  = pulse_position_ff;
      frame_bits_in      = bits;
      colon_flag_in      = take_start ? !colon_flag_ff : colon_flag_ff;
      frame_active_in    = active;
      powerup_pending_in = powerup_pending_ff;
      in_trail_in        = trail;
      rsp                = '0;

      if (active) begin
         rsp.clock_pulse = 1'b1;
         rsp.busy_res    = 1'b1;
         if (!trail) begin
            // The frame shifts out of its top bit once the header is sent.
            if (pos == HEAD_ONE_POS) begin
               rsp.data_level = 1'b1;
            end else if (pos >= HEAD_DATA_POS) begin
               rsp.data_level = bits[FRAME_DATA_BITS-1];
               frame_bits_in  = {bits[FRAME_DATA_BITS-2:0], 1'b0};
            end
            if (pos == HEAD_LAST_POS) begin
               in_trail_in       = 1'b1;
               pulse_position_in = '0;
            end else begin
               pulse_position_in = pos + 1'b1;
            end
         end else begin
            if (pos == TRAIL_LAST_POS) begin
               frame_active_in   = 1'b0;
               in_trail_in       = 1'b0;
               pulse_position_in = '0;
               rsp.frame_done    = 1'b1;
            end else begin
               pulse_position_in = pos + 1'b1;
            end
         end
      end else if (powerup_pending_ff) begin
         rsp.clock_pulse = 1'b1;
         rsp.busy_res    = 1'b1;
         if (pulse_position_ff == TRAIL_LAST_POS) begin
            powerup_pending_in = 1'b0;
            pulse_position_in  = '0;
         end else begin
            pulse_position_in = pulse_position_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_position_ff  <= '0;
         colon_flag_ff      <= 1'b0;
         frame_active_ff    <= 1'b0;
         powerup_pending_ff <= 1'b1;
         in_trail_ff        <= 1'b0;
      end else if (step) begin
         pulse_position_ff  <= pulse_position_in;
         colon_flag_ff      <= colon_flag_in;
         frame_active_ff    <= frame_active_in;
         powerup_pending_ff <= powerup_pending_in;
         in_trail_ff        <= in_trail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         frame_bits_ff <= frame_bits_in;
      end
   end

endmodule

// ----- design/clock_display_frame_serializer_unit.sv -----
// Clock display frame serializer: one request per bit period, one response per request.
// Each request passes through the input register and then the response register.
// Throughput: one request per cycle; the input register and the response register
// each advance whenever the stage after them can take data.
// Reset: synchronous; the first 100 (TRAIL_PULSES) requests give the power-up idle run.
// Depends on cdfs_pkg and cdfs_sequencer.
module clock_display_frame_serializer_unit #(
   parameter int TRAIL_PULSES = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdfs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdfs_pkg::rsp_type rsp_data
);
   import cdfs_pkg::*;

   logic    req_valid_ff;
   req_type req_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    out_free;
   logic    step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cdfs_sequencer #(
      .TRAIL_PULSES (TRAIL_PULSES)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data_ff),
      .rsp   (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_done_is_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_done |-> rsp_data_ff.busy_res &&
      rsp_data_ff.clock_pulse)
      else $error("frame end reported outside a busy pulse");

   a_data_needs_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.data_level |-> rsp_data_ff.clock_pulse)
      else $error("data high without a clock pulse");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !out_free |=> req_valid_ff && $stable(req_data_ff))
      else $error("input register lost a request while stalled");
`endif

endmodule
